// File: src/crsf_pkg.sv
// Shared constants, result kind codes and the CRC-8 step for the CRSF receiver.
// No dependencies.
`timescale 1ns / 1ps
package crsf_pkg;
  localparam int BufBytesDef    = 67;
  localparam int NumChannelsDef = 16;
  localparam int ResCap         = 64;
  localparam int MinFrameLen    = 3;
  localparam logic [7:0] CrcPoly = 8'hD5;

  localparam logic [2:0] REG_DEST_ADDRESS  = 3'd0;
  localparam logic [2:0] REG_CHANNELS_TYPE = 3'd1;
  localparam logic [2:0] REG_LINK_STATS    = 3'd2;
  localparam logic [2:0] REG_MAX_FRAME_LEN = 3'd3;
  localparam logic [2:0] REG_TIMEOUT_MS    = 3'd4;

  typedef enum logic [1:0] {
    KIND_CHANNEL = 2'd0,
    KIND_STATS   = 2'd1,
    KIND_LOST    = 2'd2
  } kind_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in);
    logic [7:0] c;
    c = crc_in;
    for (int b = 0; b < 8; b++) begin
      c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction
endpackage

// File: src/crsf_buf.sv
// Frame byte store: one write port and one registered read port.
// Depends on crsf_pkg for the default depth.
`timescale 1ns / 1ps
module crsf_buf
  import crsf_pkg::*;
#(
  parameter int BUF_BYTES = BufBytesDef,
  localparam int AW = $clog2(BUF_BYTES)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);
  logic [7:0] mem [BUF_BYTES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// File: src/crsf_frame_receiver_unit.sv
// Top level of the CRSF frame receiver: sequencer, CRC unit and decoder.
// Depends on crsf_pkg and crsf_buf.
//
//   port group | direction | carries
//   in_*       | input     | one word: received byte or millisecond tick
//   out_*      | output    | one word: channel value, statistics byte or link loss
//   cfg_*      | input     | one register write: index and data
//
// A tick is handled in the idle state and may add a result handshake. After a byte the
// buffer is rescanned: each CRC pass feeds every covered byte from the shared read port
// of the buffer through the CRC unit, each length check reads the length byte, each channel
// reads three bytes and each statistics byte reads one.
// Reset is synchronous and empties the buffer at once. A stalled output holds the
// sequencer; in_ready and cfg_ready are low until it is idle.
`timescale 1ns / 1ps
module crsf_frame_receiver_unit
  import crsf_pkg::*;
#(
  parameter int BUF_BYTES    = BufBytesDef,
  parameter int NUM_CHANNELS = NumChannelsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [3:0]  out_item_index,
  output logic [10:0] out_item_value,
  output logic        out_last,
  output logic        out_link_up,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_data
);
  localparam int AW = $clog2(BUF_BYTES);
  localparam int CW = $clog2(BUF_BYTES + 1);
  localparam int SW = AW + 2;
  localparam logic [SW-1:0] BufS = SW'(BUF_BYTES);
  localparam logic [6:0] MaxCap = 7'(BUF_BYTES - 2);
  localparam logic [CW-1:0] BufFull = CW'(BUF_BYTES);
  localparam logic [3:0] LastChan = 4'(NUM_CHANNELS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_LEN, S_CRC_RD, S_CRC_ACC, S_CHK_RD, S_CHK, S_ADR_RD, S_ADR,
    S_CH_RD, S_CH_GET, S_CH_EMIT, S_ST_RD, S_ST_GET, S_OUT, S_DROP
  } state_t;

  state_t        state_r, ret_r;
  logic [7:0]    dest_r, chan_type_r, stat_type_r;
  logic [6:0]    max_len_r;
  logic [10:0]   timeout_r, ms_r;
  logic          conn_r;
  logic [AW-1:0] head_r;
  logic [CW-1:0] fill_r;
  logic [7:0]    len_r, crc_r, type_r;
  logic [7:0]    idx_r;
  logic [7:0]    pos_r;
  logic [3:0]    chan_r;
  logic [1:0]    part_r;
  logic [23:0]   sh_r;
  logic [6:0]    res_cnt_r;
  logic          out_valid_r, out_last_r, out_link_r;
  kind_t         out_kind_r;
  logic [3:0]    out_index_r;
  logic [10:0]   out_value_r;

  logic [7:0]    mem_q;
  logic [SW-1:0] rd_off, rd_sum, wr_sum;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  logic [6:0]    maxl;
  logic [7:0]    plen, bi, stat_n;
  logic          bi_ok, cap_hit;
  logic [10:0]   ms_inc;
  logic [23:0]   sh_val;

  assign maxl    = (max_len_r > MaxCap) ? MaxCap : max_len_r;
  assign plen    = len_r - 8'd2;
  assign stat_n  = (plen > 8'd16) ? 8'd16 : plen;
  assign bi      = {3'd0, pos_r[7:3]} + {6'd0, part_r};
  assign bi_ok   = bi < plen;
  assign cap_hit = res_cnt_r >= 7'(ResCap);
  assign ms_inc  = (ms_r == 11'h7FF) ? ms_r : ms_r + 11'd1;
  assign sh_val  = sh_r >> pos_r[2:0];

  always_comb begin
    unique case (state_r)
      S_SCAN:   rd_off = SW'(1);
      S_CRC_RD: rd_off = SW'(idx_r) + SW'(2);
      S_CHK_RD: rd_off = SW'(len_r) + SW'(1);
      S_CH_RD:  rd_off = bi_ok ? SW'(bi) + SW'(3) : '0;
      S_ST_RD:  rd_off = SW'(idx_r) + SW'(3);
      default:  rd_off = '0;
    endcase
    rd_sum  = SW'(head_r) + rd_off;
    rd_addr = AW'((rd_sum >= BufS) ? rd_sum - BufS : rd_sum);
    wr_sum  = SW'(head_r) + SW'(fill_r);
    if (fill_r == BufFull) begin
      wr_addr = head_r;
    end else begin
      wr_addr = AW'((wr_sum >= BufS) ? wr_sum - BufS : wr_sum);
    end
    wr_en = (state_r == S_IDLE) && in_valid && !in_req_type;
  end

  crsf_buf #(.BUF_BYTES(BUF_BYTES)) u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_rx_byte),
    .rd_addr (rd_addr),
    .rd_data (mem_q)
  );

  function automatic logic [AW-1:0] adv(input logic [AW-1:0] h, input logic [SW-1:0] n);
    logic [SW-1:0] s;
    s = SW'(h) + n;
    return AW'((s >= BufS) ? s - BufS : s);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      dest_r      <= 8'd200;
      chan_type_r <= 8'd22;
      stat_type_r <= 8'd20;
      max_len_r   <= 7'd64;
      timeout_r   <= 11'd1000;
      ms_r        <= '0;
      conn_r      <= 1'b0;
      head_r      <= '0;
      fill_r      <= '0;
      res_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_DEST_ADDRESS:  dest_r      <= cfg_data[7:0];
          REG_CHANNELS_TYPE: chan_type_r <= cfg_data[7:0];
          REG_LINK_STATS:    stat_type_r <= cfg_data[7:0];
          REG_MAX_FRAME_LEN: max_len_r   <= cfg_data[6:0];
          REG_TIMEOUT_MS:    timeout_r   <= cfg_data;
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            res_cnt_r <= '0;
            if (in_req_type) begin
              ms_r <= ms_inc;
              if (ms_inc > timeout_r && conn_r) begin
                conn_r      <= 1'b0;
                out_valid_r <= 1'b1;
                out_kind_r  <= KIND_LOST;
                out_index_r <= '0;
                out_value_r <= '0;
                out_last_r  <= 1'b1;
                out_link_r  <= 1'b0;
                ret_r       <= S_IDLE;
                state_r     <= S_OUT;
              end
            end else begin
              if (fill_r == BufFull) begin
                head_r <= adv(head_r, SW'(1));
              end else begin
                fill_r <= fill_r + CW'(1);
              end
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: state_r <= (fill_r >= CW'(2)) ? S_LEN : S_IDLE;
        S_LEN: begin
          len_r <= mem_q;
          if (mem_q < 8'(MinFrameLen) || mem_q > {1'b0, maxl}) begin
            head_r  <= adv(head_r, SW'(1));
            fill_r  <= fill_r - CW'(1);
            state_r <= S_SCAN;
          end else if ({1'b0, fill_r} < 9'(CW'(0)) + {1'b0, mem_q} + 9'd2) begin
            state_r <= S_IDLE;
          end else begin
            crc_r   <= '0;
            idx_r   <= '0;
            state_r <= S_CRC_RD;
          end
        end
        S_CRC_RD: state_r <= S_CRC_ACC;
        S_CRC_ACC: begin
          crc_r <= crc8_byte(crc_r ^ mem_q);
          if (idx_r == 8'd0) begin
            type_r <= mem_q;
          end
          if (idx_r == len_r - 8'd2) begin
            state_r <= S_CHK_RD;
          end else begin
            idx_r   <= idx_r + 8'd1;
            state_r <= S_CRC_RD;
          end
        end
        S_CHK_RD: state_r <= S_CHK;
        S_CHK: begin
          if (mem_q == crc_r) begin
            state_r <= S_ADR_RD;
          end else begin
            head_r  <= adv(head_r, SW'(1));
            fill_r  <= fill_r - CW'(1);
            state_r <= S_SCAN;
          end
        end
        S_ADR_RD: state_r <= S_ADR;
        S_ADR: begin
          priority if (mem_q != dest_r) begin
            state_r <= S_DROP;
          end else if (type_r == chan_type_r) begin
            ms_r    <= '0;
            conn_r  <= 1'b1;
            chan_r  <= '0;
            pos_r   <= '0;
            part_r  <= '0;
            state_r <= S_CH_RD;
          end else if (type_r == stat_type_r) begin
            idx_r   <= '0;
            state_r <= S_ST_RD;
          end else begin
            state_r <= S_DROP;
          end
        end
        S_CH_RD: state_r <= S_CH_GET;
        S_CH_GET: begin
          sh_r <= {(bi_ok ? mem_q : 8'd0), sh_r[23:8]};
          if (part_r == 2'd2) begin
            state_r <= S_CH_EMIT;
          end else begin
            part_r  <= part_r + 2'd1;
            state_r <= S_CH_RD;
          end
        end
        S_CH_EMIT: begin
          pos_r  <= pos_r + 8'd11;
          chan_r <= chan_r + 4'd1;
          part_r <= '0;
          if (!cap_hit) begin
            res_cnt_r   <= res_cnt_r + 7'd1;
            out_valid_r <= 1'b1;
            out_kind_r  <= KIND_CHANNEL;
            out_index_r <= chan_r;
            out_value_r <= sh_val[10:0];
            out_last_r  <= chan_r == LastChan;
            out_link_r  <= conn_r;
            state_r     <= S_OUT;
          end else begin
            state_r <= (chan_r == LastChan) ? S_DROP : S_CH_RD;
          end
          ret_r <= (chan_r == LastChan) ? S_DROP : S_CH_RD;
        end
        S_ST_RD: state_r <= S_ST_GET;
        S_ST_GET: begin
          idx_r <= idx_r + 8'd1;
          ret_r <= (idx_r == stat_n - 8'd1) ? S_DROP : S_ST_RD;
          if (!cap_hit) begin
            res_cnt_r   <= res_cnt_r + 7'd1;
            out_valid_r <= 1'b1;
            out_kind_r  <= KIND_STATS;
            out_index_r <= idx_r[3:0];
            out_value_r <= {3'd0, mem_q};
            out_last_r  <= idx_r == stat_n - 8'd1;
            out_link_r  <= conn_r;
            state_r     <= S_OUT;
          end else begin
            state_r <= (idx_r == stat_n - 8'd1) ? S_DROP : S_ST_RD;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            state_r     <= ret_r;
          end
        end
        S_DROP: begin
          head_r  <= adv(head_r, SW'(len_r) + SW'(2));
          fill_r  <= fill_r - CW'(len_r) - CW'(2);
          state_r <= S_SCAN;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready       = state_r == S_IDLE;
  assign cfg_ready      = state_r == S_IDLE;
  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_item_index = out_index_r;
  assign out_item_value = out_value_r;
  assign out_last       = out_last_r;
  assign out_link_up    = out_link_r;
endmodule

// File: tb/tb_crsf_frame_receiver_unit.sv
// Self-checking testbench for crsf_frame_receiver_unit: directed and random byte streams
// and ticks, with a built-in predictor of the frame parser. Depends on crsf_pkg and the RTL.
`timescale 1ns / 1ps
module tb_crsf_frame_receiver_unit;
  import crsf_pkg::*;

  localparam int BufDepth  = 67;
  localparam int NumChan   = 16;
  localparam int StallLim  = 20000;
  localparam int SettleCyc = 600;

  typedef struct packed {
    logic       is_tick;
    logic [7:0] data;
  } rx_word_t;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  index;
    logic [10:0] value;
    logic        last;
    logic        link_up;
  } rx_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_req_type = 1'b0;
  logic [7:0] in_rx_byte = 8'd0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_kind;
  logic [3:0] out_item_index;
  logic [10:0] out_item_value;
  logic out_last;
  logic out_link_up;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = 3'd0;
  logic [10:0] cfg_data = 11'd0;

  crsf_frame_receiver_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_req_type(in_req_type), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_kind(out_kind), .out_item_index(out_item_index),
    .out_item_value(out_item_value), .out_last(out_last),
    .out_link_up(out_link_up),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rx_word_t   pending_words[$];
  rx_result_t expected_results[$];
  int errors = 0;
  int words_sent = 0;
  int results_seen = 0;
  bit no_idle = 1'b0;
  bit holdoff_req = 1'b0;
  bit in_taken = 1'b0;
  int quiet_cycles = 0;

  logic [7:0]  m_dest, m_ch_type, m_ls_type;
  logic [6:0]  m_max_len;
  logic [10:0] m_timeout;
  logic [7:0]  m_buf[0:BufDepth-1];
  int          m_fill;
  logic [10:0] m_ms;
  logic        m_link;
  int          m_step_count;

  task automatic model_emit(kind_t k, int idx, logic [10:0] val, logic lst);
    rx_result_t r;
    if (m_step_count < ResCap) begin
      r.kind = k;
      r.index = idx[3:0];
      r.value = val;
      r.last = lst;
      r.link_up = m_link;
      expected_results.push_back(r);
      m_step_count++;
    end
  endtask

  task automatic model_drop(int n);
    if (n >= m_fill) begin
      m_fill = 0;
    end else begin
      m_fill -= n;
      for (int i = 0; i < m_fill; i++) m_buf[i] = m_buf[i + n];
    end
  endtask

  function automatic logic [7:0] frame_crc(input logic [7:0] bytes[], input int n);
    logic [7:0] c;
    c = 8'd0;
    for (int i = 0; i < n; i++) begin
      c ^= bytes[i];
      for (int b = 0; b < 8; b++) c = c[7] ? ((c << 1) ^ 8'hD5) : (c << 1);
    end
    return c;
  endfunction

  task automatic model_decode(int len);
    int plen, n, bitpos, bi;
    logic [10:0] v;
    logic [7:0] by;
    plen = len - 2;
    if (m_buf[0] != m_dest) return;
    if (m_buf[2] == m_ch_type) begin
      m_ms = 11'd0;
      m_link = 1'b1;
      for (int c = 0; c < NumChan; c++) begin
        v = 11'd0;
        for (int k = 0; k < 11; k++) begin
          bitpos = c * 11 + k;
          bi = bitpos >> 3;
          by = (bi < plen) ? m_buf[3 + bi] : 8'd0;
          v[k] = by[bitpos & 7];
        end
        model_emit(KIND_CHANNEL, c, v, c == NumChan - 1);
      end
    end else if (m_buf[2] == m_ls_type) begin
      n = (plen > 16) ? 16 : plen;
      for (int k = 0; k < n; k++) model_emit(KIND_STATS, k, {3'd0, m_buf[3 + k]}, k == n - 1);
    end
  endtask

  task automatic model_step(rx_word_t w);
    int maxl, len;
    logic [7:0] seg[];
    m_step_count = 0;
    if (w.is_tick) begin
      if (m_ms < 11'd2047) m_ms++;
      if (m_ms > m_timeout && m_link) begin
        m_link = 1'b0;
        model_emit(KIND_LOST, 0, 11'd0, 1'b1);
      end
    end else begin
      if (m_fill >= BufDepth) model_drop(1);
      m_buf[m_fill] = w.data;
      m_fill++;
      maxl = (m_max_len > BufDepth - 2) ? BufDepth - 2 : m_max_len;
      while (m_fill >= 2) begin
        len = m_buf[1];
        if (len < MinFrameLen || len > maxl) begin
          model_drop(1);
          continue;
        end
        if (m_fill < len + 2) break;
        seg = new[len - 1];
        for (int i = 0; i < len - 1; i++) seg[i] = m_buf[2 + i];
        if (frame_crc(seg, len - 1) == m_buf[len + 1]) begin
          model_decode(len);
          model_drop(len + 2);
        end else begin
          model_drop(1);
        end
      end
    end
  endtask

  task automatic model_config(logic [2:0] idx, logic [10:0] val);
    case (idx)
      REG_DEST_ADDRESS:  m_dest = val[7:0];
      REG_CHANNELS_TYPE: m_ch_type = val[7:0];
      REG_LINK_STATS:    m_ls_type = val[7:0];
      REG_MAX_FRAME_LEN: m_max_len = val[6:0];
      REG_TIMEOUT_MS:    m_timeout = val;
      default: ;
    endcase
  endtask

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (pending_words.size() > 0 && (no_idle || $urandom_range(99) >= 37)) begin
        rx_word_t w;
        w = pending_words.pop_front();
        in_valid <= 1'b1;
        in_req_type <= w.is_tick;
        in_rx_byte <= w.data;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  int holdoff_left = 0;
  bit holdoff_done = 1'b0;
  always @(negedge clk) begin
    if (holdoff_req && !holdoff_done) begin
      holdoff_done = 1'b1;
      holdoff_left = 3000;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_idle || ($urandom_range(99) >= 37);
    end
  end

  always @(posedge clk) begin
    rx_result_t exp_r;
    rx_word_t w;
    bit fired;
    fired = 1'b0;
    in_taken = in_valid && in_ready && rst_n;
    if (in_taken) begin
      w.is_tick = in_req_type;
      w.data = in_rx_byte;
      model_step(w);
      words_sent++;
      fired = 1'b1;
    end
    if (rst_n && out_valid && out_ready) begin
      fired = 1'b1;
      results_seen++;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected word kind=%0d index=%0d value=%0d", $time,
                 out_kind, out_item_index, out_item_value);
      end else begin
        exp_r = expected_results.pop_front();
        if (out_kind != exp_r.kind) begin
          errors++;
          $display("%0t: kind expected %0d actual %0d", $time, exp_r.kind, out_kind);
        end
        if (out_item_index != exp_r.index) begin
          errors++;
          $display("%0t: index expected %0d actual %0d", $time, exp_r.index, out_item_index);
        end
        if (out_item_value != exp_r.value) begin
          errors++;
          $display("%0t: value expected %0d actual %0d", $time, exp_r.value, out_item_value);
        end
        if (out_last != exp_r.last) begin
          errors++;
          $display("%0t: last expected %0d actual %0d", $time, exp_r.last, out_last);
        end
        if (out_link_up != exp_r.link_up) begin
          errors++;
          $display("%0t: link_up expected %0d actual %0d", $time, exp_r.link_up, out_link_up);
        end
      end
    end
    if (cfg_valid && cfg_ready) fired = 1'b1;
    if (fired || !rst_n) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLim) begin
      $display("%0t: no progress for %0d cycles", $time, StallLim);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [10:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    model_config(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all(logic [7:0] dest, logic [7:0] cht, logic [7:0] lst,
                           logic [6:0] maxl, logic [10:0] tmo);
    write_reg(REG_DEST_ADDRESS, {3'd0, dest});
    write_reg(REG_CHANNELS_TYPE, {3'd0, cht});
    write_reg(REG_LINK_STATS, {3'd0, lst});
    write_reg(REG_MAX_FRAME_LEN, {4'd0, maxl});
    write_reg(REG_TIMEOUT_MS, tmo);
  endtask

  task automatic push_byte(logic [7:0] b);
    rx_word_t w;
    w.is_tick = 1'b0;
    w.data = b;
    pending_words.push_back(w);
  endtask

  task automatic push_ticks(int n);
    rx_word_t w;
    for (int i = 0; i < n; i++) begin
      w.is_tick = 1'b1;
      w.data = $urandom_range(255);
      pending_words.push_back(w);
    end
  endtask

  task automatic push_frame(logic [7:0] addr, logic [7:0] ftype, int plen, bit bad_crc);
    logic [7:0] body[];
    logic [7:0] c;
    body = new[plen + 1];
    body[0] = ftype;
    for (int i = 1; i <= plen; i++) body[i] = $urandom_range(255);
    c = frame_crc(body, plen + 1);
    if (bad_crc) c ^= 8'(1 << $urandom_range(7));
    push_byte(addr);
    push_byte(8'(plen + 2));
    for (int i = 0; i <= plen; i++) push_byte(body[i]);
    push_byte(c);
  endtask

  task automatic drain();
    wait (pending_words.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (SettleCyc) @(posedge clk);
  endtask

  task automatic random_phase(int n_words);
    int start, plen, maxp, sel;
    logic [7:0] ty;
    start = pending_words.size();
    maxp = ((m_max_len > BufDepth - 2) ? BufDepth - 2 : m_max_len) - 2;
    while (pending_words.size() - start < n_words) begin
      sel = $urandom_range(99);
      if (sel < 70) begin
        case ($urandom_range(2))
          0: ty = m_ch_type;
          1: ty = m_ls_type;
          default: ty = $urandom_range(255);
        endcase
        plen = ($urandom_range(3) == 0) ? $urandom_range(maxp, 1) : $urandom_range(22, 1);
        if (plen > maxp) plen = maxp;
        push_frame(($urandom_range(4) == 0) ? 8'($urandom_range(255)) : m_dest, ty, plen,
                   $urandom_range(9) == 0);
      end else if (sel < 85) begin
        repeat ($urandom_range(4, 1)) push_byte($urandom_range(255));
      end else begin
        push_ticks($urandom_range(12, 1));
      end
    end
  endtask

  initial begin
    m_dest = 8'd200;
    m_ch_type = 8'd22;
    m_ls_type = 8'd20;
    m_max_len = 7'd64;
    m_timeout = 11'd1000;
    m_fill = 0;
    m_ms = 11'd0;
    m_link = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Defaults: full channel frame, statistics, bad length, CRC miss, foreign frames.
    push_frame(8'd200, 8'd22, 22, 1'b0);
    push_frame(8'd200, 8'd20, 10, 1'b0);
    push_byte(8'd200); push_byte(8'd1);
    push_frame(8'd200, 8'd20, 4, 1'b1);
    push_frame(8'd17, 8'd22, 22, 1'b0);
    push_frame(8'd200, 8'd99, 5, 1'b0);
    push_frame(8'd200, 8'd22, 3, 1'b0);
    push_frame(8'd200, 8'd20, 20, 1'b0);
    push_byte(8'd200); push_byte(8'd65);
    push_byte(8'd0); push_byte(8'd255);
    // A broken long header that hides two good frames, both completed by one word.
    push_byte(8'd200); push_byte(8'd12);
    push_frame(8'd200, 8'd20, 1, 1'b0);
    push_frame(8'd200, 8'd22, 2, 1'b0);
    push_byte(8'h5A);
    push_ticks(3);
    drain();

    write_all(8'd0, 8'd255, 8'd0, 7'd3, 11'd1);
    push_frame(8'd0, 8'd0, 1, 1'b0);
    push_frame(8'd0, 8'd0, 2, 1'b0);
    push_frame(8'd0, 8'd255, 1, 1'b0);
    push_ticks(3);
    drain();

    write_all(8'd255, 8'd77, 8'd77, 7'd64, 11'd2047);
    push_frame(8'd255, 8'd77, 22, 1'b0);
    push_frame(8'd255, 8'd77, 62, 1'b0);
    push_ticks(4);
    drain();

    write_all(8'd200, 8'd22, 8'd20, 7'd64, 11'd6);
    random_phase(25);
    drain();

    no_idle = 1'b1;
    write_all($urandom_range(255), 8'd22, 8'd20, 7'd40, 11'd3);
    random_phase(25);
    drain();
    no_idle = 1'b0;

    write_all(8'd200, 8'd10, 8'd11, 7'd30, 11'd20);
    holdoff_req = 1'b1;
    random_phase(25);
    drain();

    write_all(8'd200, 8'd22, 8'd20, 7'd65, 11'd2);
    random_phase(25);
    drain();

    $display("Sent %0d input words and checked %0d result words over seven settings,",
             words_sent, results_seen);
    $display("including a long output hold-off and a stretch without idling.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
